// ===== sv/iol_pkg.sv =====
// Shared types and constants for the indexed ordered list unit.
// No dependencies; imported by iol_ctrl, iol_dpath and the top level.
package iol_pkg;

  localparam int DEPTH     = 64;
  localparam int WORD_BITS = 32;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_READ   = 3'd2,
    OP_WRITE  = 3'd3,
    OP_REMOVE = 3'd4,
    OP_POP    = 3'd5,
    OP_FIND   = 3'd6,
    OP_CLEAR  = 3'd7
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Walk engine modes: shift up (insert), shift down (remove), search.
  typedef enum logic [1:0] {
    WALK_UP   = 2'd0,
    WALK_DN   = 2'd1,
    WALK_FIND = 2'd2
  } walk_e;

  typedef struct packed {
    logic    load_req;
    logic    append_wr;
    logic    pos_wr;
    logic    rd_pos;
    logic    cap_eout;
    logic    walk_init;
    walk_e   walk_mode;
    logic    walk_run;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    cnt_clr;
    logic    set_status;
    status_e status;
    logic    res_load;
  } iol_cmd_t;

  typedef struct packed {
    opcode_e op;
    logic    rng_ins;
    logic    rng_acc;
    logic    full;
    logic    walk_done;
  } iol_stat_t;

endpackage

// ===== sv/iol_dpath.sv =====
// Datapath: request registers, entry memory, count, walk engine, result registers.
// Depends on iol_pkg.
module iol_dpath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  iol_pkg::iol_cmd_t            cmd_i,
  output iol_pkg::iol_stat_t           st_o,
  input  logic [2:0]                   opcode_i,
  input  logic [iol_pkg::IDX_W-1:0]    position_i,
  input  logic [iol_pkg::WORD_BITS-1:0] element_i,
  output logic [1:0]                   status_o,
  output logic [iol_pkg::WORD_BITS-1:0] element_out_o,
  output logic                         found_o,
  output logic [iol_pkg::IDX_W-1:0]    found_position_o,
  output logic [iol_pkg::CNT_W-1:0]    length_o
);
  import iol_pkg::*;

  logic [WORD_BITS-1:0] mem [DEPTH];

  opcode_e              op_q;
  logic [IDX_W-1:0]     pos_q;
  logic [WORD_BITS-1:0] word_q;
  status_e              status_q;
  logic [WORD_BITS-1:0] eout_q;
  logic                 found_q;
  logic [IDX_W-1:0]     fpos_q;
  logic [CNT_W-1:0]     cnt_q;

  walk_e                mode_q;
  logic [IDX_W-1:0]     src_q;
  logic [IDX_W-1:0]     tag_q;
  logic [CNT_W-1:0]     rem_q;
  logic [CNT_W-1:0]     rem_init;
  logic [IDX_W-1:0]     src_init;
  logic                 pend_q;
  logic [WORD_BITS-1:0] rd_q;

  logic                 issue;
  logic                 hit;
  logic                 we;
  logic [IDX_W-1:0]     wa;
  logic [WORD_BITS-1:0] wd;
  logic                 re;
  logic [IDX_W-1:0]     ra;
  logic [IDX_W-1:0]     dst;

  always_comb begin
    issue = cmd_i.walk_run && (rem_q != '0);
    hit   = cmd_i.walk_run && pend_q && (mode_q == WALK_FIND) && (rd_q == word_q);
    dst   = (mode_q == WALK_UP) ? tag_q + IDX_W'(1) : tag_q - IDX_W'(1);

    we = 1'b0;
    wa = pos_q;
    wd = word_q;
    if (cmd_i.append_wr) begin
      we = 1'b1;
      wa = cnt_q[IDX_W-1:0];
    end else if (cmd_i.pos_wr) begin
      we = 1'b1;
    end else if (cmd_i.walk_run && pend_q && (mode_q != WALK_FIND)) begin
      we = 1'b1;
      wa = dst;
      wd = rd_q;
    end

    re = cmd_i.rd_pos || issue;
    ra = cmd_i.rd_pos ? pos_q : src_q;

    case (cmd_i.walk_mode)
      WALK_UP: begin
        rem_init = cnt_q - {1'b0, pos_q};
        src_init = IDX_W'(cnt_q - CNT_W'(1));
      end
      WALK_DN: begin
        rem_init = cnt_q - {1'b0, pos_q} - CNT_W'(1);
        src_init = pos_q + IDX_W'(1);
      end
      default: begin
        rem_init = cnt_q;
        src_init = '0;
      end
    endcase

    st_o.op        = op_q;
    st_o.rng_ins   = {1'b0, pos_q} > cnt_q;
    st_o.rng_acc   = {1'b0, pos_q} >= cnt_q;
    st_o.full      = cnt_q == CNT_W'(DEPTH);
    st_o.walk_done = hit || ((rem_q == '0) && !pend_q);
  end

  // Entry memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_q <= mem[ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      pend_q <= 1'b0;
      rem_q  <= '0;
    end else begin
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (cmd_i.cnt_dec) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
      if (cmd_i.walk_init) begin
        pend_q <= 1'b0;
        rem_q  <= rem_init;
      end else if (cmd_i.walk_run) begin
        pend_q <= issue;
        if (issue) begin
          rem_q <= rem_q - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      op_q     <= opcode_e'(opcode_i);
      pos_q    <= position_i;
      word_q   <= element_i;
      status_q <= ST_OK;
      eout_q   <= '0;
      found_q  <= 1'b0;
      fpos_q   <= '0;
    end
    if (cmd_i.set_status) begin
      status_q <= cmd_i.status;
    end
    if (cmd_i.cap_eout) begin
      eout_q <= rd_q;
    end
    if (cmd_i.walk_init) begin
      mode_q <= cmd_i.walk_mode;
      src_q  <= src_init;
    end else if (issue) begin
      tag_q <= src_q;
      src_q <= (mode_q == WALK_UP) ? src_q - IDX_W'(1) : src_q + IDX_W'(1);
    end
    if (hit) begin
      found_q <= 1'b1;
      fpos_q  <= tag_q;
    end
    if (cmd_i.res_load) begin
      status_o         <= status_q;
      element_out_o    <= eout_q;
      found_o          <= found_q;
      found_position_o <= fpos_q;
      length_o         <= cnt_q;
    end
  end

endmodule

// ===== sv/iol_ctrl.sv =====
// Controller state machine: sequences each request through the datapath.
// Depends on iol_pkg.
module iol_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output iol_pkg::iol_cmd_t   cmd_o,
  input  iol_pkg::iol_stat_t  st_i
);
  import iol_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_CAP  = 5'b00100,
    S_WALK = 5'b01000,
    S_FIN  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_vld_q, out_vld_d;
  logic   out_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_free    = !out_vld_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_FIN;
        case (st_i.op)
          OP_APPEND: begin
            if (st_i.full) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_FULL;
            end else begin
              cmd_o.append_wr = 1'b1;
              cmd_o.cnt_inc   = 1'b1;
            end
          end
          OP_INSERT: begin
            if (st_i.rng_ins) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_RANGE;
            end else if (st_i.full) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_FULL;
            end else begin
              cmd_o.walk_init = 1'b1;
              cmd_o.walk_mode = WALK_UP;
              state_d         = S_WALK;
            end
          end
          OP_FIND: begin
            cmd_o.walk_init = 1'b1;
            cmd_o.walk_mode = WALK_FIND;
            state_d         = S_WALK;
          end
          OP_CLEAR: begin
            cmd_o.cnt_clr = 1'b1;
          end
          default: begin
            // read, write, remove, pop: position must hold an entry
            if (st_i.rng_acc) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_RANGE;
            end else if (st_i.op == OP_WRITE) begin
              cmd_o.pos_wr = 1'b1;
            end else if (st_i.op == OP_REMOVE) begin
              cmd_o.walk_init = 1'b1;
              cmd_o.walk_mode = WALK_DN;
              state_d         = S_WALK;
            end else begin
              cmd_o.rd_pos = 1'b1;
              state_d      = S_CAP;
            end
          end
        endcase
      end
      S_CAP: begin
        cmd_o.cap_eout = 1'b1;
        if (st_i.op == OP_POP) begin
          cmd_o.walk_init = 1'b1;
          cmd_o.walk_mode = WALK_DN;
          state_d         = S_WALK;
        end else begin
          state_d = S_FIN;
        end
      end
      S_WALK: begin
        cmd_o.walk_run = 1'b1;
        if (st_i.walk_done) begin
          state_d = S_FIN;
          if (st_i.op == OP_INSERT) begin
            cmd_o.pos_wr  = 1'b1;
            cmd_o.cnt_inc = 1'b1;
          end else if (st_i.op == OP_REMOVE || st_i.op == OP_POP) begin
            cmd_o.cnt_dec = 1'b1;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (cmd_o.res_load) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

endmodule

// ===== sv/indexed_ordered_list_unit.sv =====
// Indexed ordered list unit: up to 64 words with append/insert/read/write/remove/pop/find/clear.
// One request at a time; a new one is taken only after the last result is loaded. Insert,
// remove, pop and find walk the entries, moving or scanning one entry per cycle through the
// memory's single read and write port. Async active-low reset empties the list; no clear pass.
module indexed_ordered_list_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [2:0]                    opcode_i,
  input  logic [iol_pkg::IDX_W-1:0]     position_i,
  input  logic [iol_pkg::WORD_BITS-1:0] element_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    status_o,
  output logic [iol_pkg::WORD_BITS-1:0] element_out_o,
  output logic                          found_o,
  output logic [iol_pkg::IDX_W-1:0]     found_position_o,
  output logic [iol_pkg::CNT_W-1:0]     length_o
);
  import iol_pkg::*;

  // Controller issues per-cycle commands; datapath returns opcode and checks.
  iol_cmd_t  cmd;
  iol_stat_t stat;

  // The result sits in an output register, so a new request is taken while
  // the previous result still waits; the controller holds its finish step
  // until that register is free.
  iol_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .st_i        (stat)
  );

  // Entry memory, count and the walk engine: shifts are pipelined as
  // read-one / write-previous, find compares the word read last cycle.
  iol_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .st_o             (stat),
    .opcode_i         (opcode_i),
    .position_i       (position_i),
    .element_i        (element_i),
    .status_o         (status_o),
    .element_out_o    (element_out_o),
    .found_o          (found_o),
    .found_position_o (found_position_o),
    .length_o         (length_o)
  );

endmodule
